### rtl/b32dx_pkg.sv
// ----------------------------------------------------------------------------
// b32dx_pkg
// shared types and constants of the base-32 decode and unscramble unit
// ----------------------------------------------------------------------------
package b32dx_pkg;

  // widths fixed by the field definitions
  localparam int unsigned CharW   = 8;
  localparam int unsigned DigitW  = 5;
  localparam int unsigned WordW   = 32;
  localparam int unsigned OutWords = 4;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] KEY_WORD0_IDX = 2'd0;
  localparam logic [CfgIdxW-1:0] KEY_WORD1_IDX = 2'd1;
  localparam logic [CfgIdxW-1:0] KEY_WORD2_IDX = 2'd2;
  localparam logic [CfgIdxW-1:0] KEY_WORD3_IDX = 2'd3;

  // one decoded character
  typedef struct packed {
    logic              valid;
    logic [DigitW-1:0] digit;
  } digit_t;

  // one finished string, before or after unscrambling
  typedef struct packed {
    logic [OutWords-1:0][WordW-1:0] words;
    logic                           bad_char;
    logic                           overflowed;
  } result_t;

endpackage

### rtl/b32dx_char_map.sv
// ----------------------------------------------------------------------------
// b32dx_char_map
// maps an ascii code onto its 5-bit base-32 digit, flags codes outside the set
// ----------------------------------------------------------------------------
module b32dx_char_map (
  input  logic [b32dx_pkg::CharW-1:0] char_code_i,
  output b32dx_pkg::digit_t           digit_o
);

  logic [b32dx_pkg::CharW-1:0] offset;
  logic [b32dx_pkg::CharW-1:0] diff;

  // alphabet is digits then consonants and 'U'; 'A', 'E', 'I' and 'O' are holes
  always_comb begin
    offset        = '0;
    digit_o.valid = 1'b1;
    case (char_code_i) inside
      ["0":"9"]: offset = 8'd48;
      ["B":"D"]: offset = 8'd56;
      ["F":"H"]: offset = 8'd57;
      ["J":"N"]: offset = 8'd58;
      ["P":"Z"]: offset = 8'd59;
      default:   digit_o.valid = 1'b0;
    endcase
    diff          = char_code_i - offset;
    digit_o.digit = diff[b32dx_pkg::DigitW-1:0];
  end

endmodule

### rtl/b32dx_accum.sv
// ----------------------------------------------------------------------------
// b32dx_accum
// shift-in accumulator with sticky error and overflow flags
// ----------------------------------------------------------------------------
module b32dx_accum #(
  parameter int unsigned NUM_WORDS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  b32dx_pkg::digit_t   digit_i,
  input  logic                last_i,
  output b32dx_pkg::result_t  result_o
);

  localparam int unsigned AccW = NUM_WORDS * b32dx_pkg::WordW;
  localparam int unsigned DW   = b32dx_pkg::DigitW;

  logic [AccW-1:0] acc_q, acc_d, acc_next;
  logic            err_q, err_d, err_next;
  logic            ovf_q, ovf_d, ovf_next;

  // state after this character: a bad one freezes conversion
  always_comb begin
    acc_next = acc_q;
    err_next = err_q;
    ovf_next = ovf_q;
    if (!err_q) begin
      if (digit_i.valid) begin
        acc_next = {acc_q[AccW-DW-1:0], digit_i.digit};
        if (acc_q[AccW-1 -: DW] != '0) begin
          ovf_next = 1'b1;
        end
      end else begin
        err_next = 1'b1;
      end
    end
  end

  // the last character hands the string off and clears the state
  always_comb begin
    acc_d = acc_q;
    err_d = err_q;
    ovf_d = ovf_q;
    if (step_i) begin
      if (last_i) begin
        acc_d = '0;
        err_d = 1'b0;
        ovf_d = 1'b0;
      end else begin
        acc_d = acc_next;
        err_d = err_next;
        ovf_d = ovf_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      err_q <= 1'b0;
      ovf_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      err_q <= err_d;
      ovf_q <= ovf_d;
    end
  end

  // low words go out; words beyond the accumulator read as zero
  for (genvar w = 0; w < b32dx_pkg::OutWords; w++) begin : g_out
    if (w < NUM_WORDS) begin : g_live
      assign result_o.words[w] = acc_next[w*b32dx_pkg::WordW +: b32dx_pkg::WordW];
    end else begin : g_zero
      assign result_o.words[w] = '0;
    end
  end

  assign result_o.bad_char   = err_next;
  assign result_o.overflowed = ovf_next;

endmodule

### rtl/base32_decode_xor_unscramble_unit.sv
// ----------------------------------------------------------------------------
// base32_decode_xor_unscramble_unit
// decodes a base-32 string one character per transfer, unscrambles it with
// the key words and sends one 128-bit result per string
// ----------------------------------------------------------------------------
// the last character goes through the input register, then the result register
// that drives the result's tvalid
// throughput: one character per cycle while no last character waits on a busy result
// reset: clears the accumulator, both flags, the key words and both valids
module base32_decode_xor_unscramble_unit #(
  parameter int unsigned NUM_WORDS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // character stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] char_code
  input  logic         s_axis_tlast,   // last_char
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // [31:0] word0, [63:32] word1,
                                       // [95:64] word2, [127:96] word3
  output logic [1:0]   m_axis_tuser,   // [0] bad_char, [1] overflowed
  // key word writes
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i
);

  // key registers
  logic [b32dx_pkg::OutWords-1:0][b32dx_pkg::WordW-1:0] key_q, key_d;

  always_comb begin
    key_d = key_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        b32dx_pkg::KEY_WORD0_IDX: key_d[0] = cfg_wdata_i;
        b32dx_pkg::KEY_WORD1_IDX: key_d[1] = cfg_wdata_i;
        b32dx_pkg::KEY_WORD2_IDX: key_d[2] = cfg_wdata_i;
        b32dx_pkg::KEY_WORD3_IDX: key_d[3] = cfg_wdata_i;
        default: key_d = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  // input register
  logic                       in_vld_q;
  logic [b32dx_pkg::CharW-1:0] char_q;
  logic                       last_q;
  logic                       out_free;
  logic                       advance;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_vld_q && (!last_q || out_free);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      char_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  // character decode and accumulate
  b32dx_pkg::digit_t  digit;
  b32dx_pkg::result_t raw;

  b32dx_char_map u_char_map (
    .char_code_i (char_q),
    .digit_o     (digit)
  );

  b32dx_accum #(
    .NUM_WORDS (NUM_WORDS)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .digit_i  (digit),
    .last_i   (last_q),
    .result_o (raw)
  );

  // unscramble only the words the accumulator really has
  b32dx_pkg::result_t res_d, res_q;
  logic               out_vld_q;

  always_comb begin
    res_d = raw;
    for (int w = 0; w < b32dx_pkg::OutWords; w++) begin
      if (w < NUM_WORDS) begin
        res_d.words[w] = raw.words[w] ^ key_q[w];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= advance && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q.words;
  assign m_axis_tuser  = {res_q.overflowed, res_q.bad_char};

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives base-32 strings into the decode and unscramble unit under random
// idling on both streams, predicts each string's unscrambled words and flags,
// and checks every result transfer against the oldest pending prediction
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned AccW        = b32dx_pkg::OutWords * b32dx_pkg::WordW;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned ItemsPerPhase = 500;

  // predictor of the decoded strings and store of the results still owed
  class string_unscrambler;
    string                       alphabet = "0123456789BCDFGHJKLMNPQRSTUVWXYZ";
    logic [b32dx_pkg::WordW-1:0] key_words [b32dx_pkg::OutWords];
    logic [AccW-1:0]             acc;
    logic                        bad_seen;
    logic                        ovf_seen;
    b32dx_pkg::result_t          owed_q[$];
    int unsigned                 mismatches;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      mismatches = 0;
      clear_string();
    endfunction

    function void clear_string();
      acc      = '0;
      bad_seen = 1'b0;
      ovf_seen = 1'b0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // alphabet position of a character, 0 if it is not in the alphabet
    function bit lookup_digit(logic [b32dx_pkg::CharW-1:0] code,
                              output logic [b32dx_pkg::DigitW-1:0] digit);
      digit = '0;
      for (int i = 0; i < 32; i++) begin
        if (alphabet[i] == code) begin
          digit = i[b32dx_pkg::DigitW-1:0];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // one accepted character; a last character closes the string
    function void note_char(logic [b32dx_pkg::CharW-1:0] code, logic last);
      logic [b32dx_pkg::DigitW-1:0] digit;
      b32dx_pkg::result_t           want;
      if (!bad_seen) begin
        if (lookup_digit(code, digit)) begin
          // bits pushed off the top end up in the overflow flag
          if (acc[AccW-1 -: b32dx_pkg::DigitW] != '0) ovf_seen = 1'b1;
          acc = {acc[AccW-b32dx_pkg::DigitW-1:0], digit};
        end else begin
          bad_seen = 1'b1;
        end
      end
      if (last) begin
        for (int i = 0; i < b32dx_pkg::OutWords; i++) begin
          want.words[i] = acc[i*b32dx_pkg::WordW +: b32dx_pkg::WordW] ^ key_words[i];
        end
        want.bad_char   = bad_seen;
        want.overflowed = ovf_seen;
        owed_q.push_back(want);
        clear_string();
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // one accepted result, compared field by field
    task check_result(logic [AccW-1:0] data, logic [1:0] flags);
      b32dx_pkg::result_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("result %h/%b with no string pending", data, flags));
      end else begin
        want = owed_q.pop_front();
        for (int i = 0; i < b32dx_pkg::OutWords; i++) begin
          if (data[i*b32dx_pkg::WordW +: b32dx_pkg::WordW] !== want.words[i]) begin
            report($sformatf("word%0d got %h want %h", i,
                             data[i*b32dx_pkg::WordW +: b32dx_pkg::WordW],
                             want.words[i]));
          end
        end
        if (flags[0] !== want.bad_char) begin
          report($sformatf("bad_char got %b want %b", flags[0], want.bad_char));
        end
        if (flags[1] !== want.overflowed) begin
          report($sformatf("overflowed got %b want %b", flags[1], want.overflowed));
        end
      end
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [b32dx_pkg::CharW-1:0]   s_axis_tdata;   // [7:0] char_code
  logic                          s_axis_tlast;   // last_char
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [AccW-1:0]               m_axis_tdata;   // [31:0] word0 .. [127:96] word3
  logic [1:0]                    m_axis_tuser;   // [0] bad_char, [1] overflowed
  logic                          cfg_we_i;
  logic [b32dx_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [b32dx_pkg::WordW-1:0]   cfg_wdata_i;

  string_unscrambler book;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  int unsigned       hold_left;
  int unsigned       items_sent;
  int unsigned       cycle_count;

  base32_decode_xor_unscramble_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result transfers go to the checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      book.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // one character transfer, with random idle cycles ahead of it
  task automatic send_char(logic [b32dx_pkg::CharW-1:0] code, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    book.note_char(code, last);
    items_sent++;
  endtask

  // a character mostly outside the alphabet; the vowel pick can give 'U', which is in it
  function automatic logic [b32dx_pkg::CharW-1:0] pick_bad_code();
    string vowels = "AEIOU";
    case ($urandom_range(3))
      0:       return 8'($urandom_range(8'h61, 8'h7a));
      1:       return vowels[$urandom_range(4)];
      2:       return 8'($urandom_range(8'h3a, 8'h40));
      default: return 8'($urandom_range(8'h80, 8'hff));
    endcase
  endfunction

  // mostly well-formed strings, some with one bad character, a few pure noise
  task automatic send_random_string();
    int unsigned                 len;
    int unsigned                 pick;
    int unsigned                 kind;
    int unsigned                 bad_pos;
    int unsigned                 zeros;
    logic [b32dx_pkg::CharW-1:0] code;
    pick = $urandom_range(99);
    if (pick < 10) len = $urandom_range(26, 32);
    else if (pick < 20) len = 1;
    else len = $urandom_range(2, 25);
    kind    = $urandom_range(99);
    bad_pos = $urandom_range(len - 1);
    zeros   = ($urandom_range(9) == 0) ? $urandom_range(len - 1) : 0;
    for (int i = 0; i < len; i++) begin
      if (kind >= 92) code = 8'($urandom_range(255));
      else if (kind >= 78 && i == bad_pos) code = pick_bad_code();
      else if (i < zeros) code = "0";
      else code = book.alphabet[$urandom_range(31)];
      send_char(code, i == len - 1);
    end
  endtask

  // sender pause until every owed result is back and the pipeline is empty
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_key(logic [b32dx_pkg::CfgIdxW-1:0] idx,
                           logic [b32dx_pkg::WordW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    book.key_words[idx] = value;
  endtask

  task automatic write_all_keys(logic [b32dx_pkg::WordW-1:0] k0,
                                logic [b32dx_pkg::WordW-1:0] k1,
                                logic [b32dx_pkg::WordW-1:0] k2,
                                logic [b32dx_pkg::WordW-1:0] k3);
    write_key(b32dx_pkg::KEY_WORD0_IDX, k0);
    write_key(b32dx_pkg::KEY_WORD1_IDX, k1);
    write_key(b32dx_pkg::KEY_WORD2_IDX, k2);
    write_key(b32dx_pkg::KEY_WORD3_IDX, k3);
  endtask

  task automatic run_random(int unsigned target);
    while (items_sent < target) send_random_string();
  endtask

  // main sequence
  initial begin
    book          = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = b32dx_pkg::KEY_WORD0_IDX;
    cfg_wdata_i   = '0;
    hold_left     = 0;
    items_sent    = 0;
    send_idle_pct = 24;
    recv_idle_pct = 65;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed strings with the reset keys
    send_char("0", 1'b1);
    send_char("Z", 1'b1);
    // leading zeros
    send_char("0", 1'b0);
    send_char("0", 1'b0);
    send_char("Z", 1'b1);
    // bad first character, the rest ignored
    send_char("A", 1'b0);
    send_char("1", 1'b1);
    // lowercase in the middle
    send_char("1", 1'b0);
    send_char("a", 1'b0);
    send_char("Z", 1'b1);
    // bad last character
    send_char("5", 1'b0);
    send_char(8'hff, 1'b1);
    // codes just outside the alphabet ranges, vowels, high codes
    send_char("/", 1'b1);
    send_char(":", 1'b1);
    send_char("@", 1'b1);
    send_char("[", 1'b1);
    send_char("E", 1'b1);
    send_char(8'h80, 1'b1);
    // edges of the digit and consonant ranges
    send_char("9", 1'b0);
    send_char("B", 1'b1);
    wait_drained();

    // slow receiver, all-ones keys
    write_all_keys('1, '1, '1, '1);
    items_sent = 0;
    run_random(ItemsPerPhase / 2);
    wait_drained();
    run_random(ItemsPerPhase);
    wait_drained();

    // slow sender, random keys
    send_idle_pct = 65;
    recv_idle_pct = 24;
    write_all_keys($urandom, $urandom, $urandom, $urandom);
    items_sent = 0;
    run_random(ItemsPerPhase);
    wait_drained();

    // no idling, mixed keys; result side held off while short strings pile up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all_keys('0, 32'ha5a5_5a5a, '1, $urandom);
    items_sent = 0;
    hold_left  = 300;
    repeat (40) send_char(book.alphabet[$urandom_range(31)], 1'b1);
    run_random(ItemsPerPhase);
    wait_drained();

    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

### base32_decode_xor_unscramble_unit.f
rtl/b32dx_pkg.sv
rtl/b32dx_char_map.sv
rtl/b32dx_accum.sv
rtl/base32_decode_xor_unscramble_unit.sv
test/testbench.sv
